@@ rtl/core/assert_macros.svh @@
// Concurrent assertion helpers; expect signals named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define SFR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked at every edge, reset included.
`define SFR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/core/sfr_pkg.sv @@
`default_nettype none

package sfr_pkg;

   localparam int MAX_PATTERN_DEF = 8;
   localparam int MAX_REPLACE_DEF = 8;
   // upper bound of both parameters: one command never holds more bytes
   localparam int MAX_OUT   = 8;
   localparam int IDX_W     = $clog2(MAX_OUT);
   localparam int CNT_W     = 4;
   localparam int QDEPTH    = 4;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 64;

   localparam logic [3:0] PATTERN_LEN_RESET = 4'd1;

   typedef enum logic [1:0] {
      REG_PATTERN_LEN   = 2'd0,
      REG_PATTERN_BYTES = 2'd1,
      REG_REPLACE_LEN   = 2'd2,
      REG_REPLACE_BYTES = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [3:0]  pattern_len;
      logic [63:0] pattern_bytes;
      logic [3:0]  replace_len;
      logic [63:0] replace_bytes;
   } cfg_type;

   // One accepted byte's worth of output: cnt beats taken from bytes,
   // or a single empty end beat when cnt is zero and last is set.
   typedef struct packed {
      logic [MAX_OUT-1:0][7:0] bytes;
      logic [CNT_W-1:0]        cnt;
      logic                    last;
   } cmd_type;

endpackage

`default_nettype wire

@@ rtl/core/sfr_req_if.sv @@
`default_nettype none

interface sfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       in_last;

   modport source (output valid, output in_char, output in_last, input ready);
   modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sfr_rsp_if.sv @@
`default_nettype none

interface sfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       has_char;
   logic       out_last;

   modport source (output valid, output out_char, output has_char, output out_last,
                   input ready);
   modport sink   (input valid, input out_char, input has_char, input out_last,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/core/sfr_front.sv @@
`default_nettype none

module sfr_front #(
   parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF,
   parameter int MAX_REPLACE = sfr_pkg::MAX_REPLACE_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   sfr_req_if.sink              req,
   input  wire sfr_pkg::cfg_type cfg,
   input  wire logic            cfg_clear,
   input  wire logic            q_full,
   output sfr_pkg::cmd_type     q_wdata,
   output logic                 q_push
);

   localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int FW = $clog2(MAX_PATTERN + 1);

   logic [7:0]    win_ff [MAX_PATTERN];
   logic [7:0]    win_in [MAX_PATTERN];
   logic [FW-1:0] fill_ff;
   logic [FW-1:0] fill_in;

   logic [7:0]    wnew [MAX_PATTERN];
   logic [3:0]    plen;
   logic [3:0]    rlen;
   logic [IW-1:0] slot;
   logic [3:0]    nfill;
   logic          full;
   logic          hit;
   logic          accept;

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;

   always_comb begin
      plen = cfg.pattern_len;
      if (plen == 4'd0) begin
         plen = 4'd1;
      end else if (plen > 4'(MAX_PATTERN)) begin
         plen = 4'(MAX_PATTERN);
      end
      rlen = (cfg.replace_len > 4'(MAX_REPLACE)) ? 4'(MAX_REPLACE) : cfg.replace_len;

      slot  = (4'(fill_ff) >= plen) ? '0 : IW'(fill_ff);
      nfill = 4'(slot) + 4'd1;
      full  = (nfill == plen);

      for (int k = 0; k < MAX_PATTERN; k++) begin
         wnew[k] = (IW'(k) == slot) ? req.in_char : win_ff[k];
      end

      hit = full;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         if (4'(k) < plen && wnew[k] != cfg.pattern_bytes[8*k +: 8]) begin
            hit = 1'b0;
         end
      end

      // Outside a hit the beats are always the window itself, oldest first.
      for (int k = 0; k < sfr_pkg::MAX_OUT; k++) begin
         if (hit) begin
            q_wdata.bytes[k] = cfg.replace_bytes[8*k +: 8];
         end else if (k < MAX_PATTERN) begin
            q_wdata.bytes[k] = wnew[k % MAX_PATTERN];
         end else begin
            q_wdata.bytes[k] = 8'd0;
         end
      end
      if (hit) begin
         q_wdata.cnt = rlen;
      end else if (req.in_last) begin
         q_wdata.cnt = nfill;
      end else begin
         q_wdata.cnt = full ? 4'd1 : 4'd0;
      end
      q_wdata.last = req.in_last;
      q_push = accept && (q_wdata.cnt != 4'd0 || req.in_last);

      win_in  = wnew;
      fill_in = fill_ff;
      if (accept) begin
         if (hit || req.in_last) begin
            fill_in = '0;
         end else if (full) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
               win_in[k] = wnew[(k + 1) % MAX_PATTERN];
            end
            fill_in = FW'(nfill - 4'd1);
         end else begin
            fill_in = FW'(nfill);
         end
      end else begin
         win_in = win_ff;
      end
      if (cfg_clear) begin
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/sfr_queue.sv @@
`default_nettype none

module sfr_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire sfr_pkg::cmd_type wdata,
   input  wire logic             pop,
   output sfr_pkg::cmd_type      head,
   output logic                  full,
   output logic                  empty
);

   localparam int PW = $clog2(sfr_pkg::QDEPTH);
   localparam int CW = $clog2(sfr_pkg::QDEPTH + 1);

   sfr_pkg::cmd_type q_ff [sfr_pkg::QDEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign head  = q_ff[rd_ptr_ff];
   assign full  = (count_ff == CW'(sfr_pkg::QDEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/sfr_back.sv @@
`default_nettype none

module sfr_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire sfr_pkg::cmd_type head,
   input  wire logic             empty,
   output logic                  pop,
   sfr_rsp_if.source             rsp
);

   logic [sfr_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       has_ff, has_in;
   logic       last_ff, last_in;
   logic       load;
   logic       final_beat;

   assign rsp.valid    = valid_ff;
   assign rsp.out_char = char_ff;
   assign rsp.has_char = has_ff;
   assign rsp.out_last = last_ff;

   always_comb begin
      final_beat = (head.cnt == '0) ||
                   ({1'b0, idx_ff} + sfr_pkg::CNT_W'(1) == head.cnt);
      load = !empty && (!valid_ff || rsp.ready);
      pop  = load && final_beat;

      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp.ready;
      char_in  = char_ff;
      has_in   = has_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         has_in   = (head.cnt != '0);
         char_in  = has_in ? head.bytes[idx_ff] : 8'd0;
         last_in  = head.last && final_beat;
         idx_in   = final_beat ? '0 : idx_ff + sfr_pkg::IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      has_ff  <= has_in;
      last_ff <= last_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/stream_find_replace.sv @@
// Streaming find and replace over a byte stream.
// req: one text byte per beat (in_char) with in_last on the final byte.
// rsp: rewritten text, one byte per beat (out_char, has_char = 1); out_last
//   marks the final beat of a text. A text that ends with nothing left to
//   send gives one empty end beat (has_char = 0, out_char = 0, out_last = 1).
// csr: APB-style write/read port, 64-bit registers at 8*index:
//   pattern_len, pattern_bytes, replace_len, replace_bytes. Writing
//   pattern_len empties the match window. Write only while the block is idle.
// Path: a byte that completes a result is registered in the command queue,
//   then in the output register, before it shows on rsp.
// Throughput: one req beat per cycle; the output side sends one beat per
//   cycle while rsp.ready is high, so a match or end-of-text flush of n bytes
//   takes n output beats. A 4-entry command queue between the classifier and
//   the output serializer absorbs that; req.ready drops only when it is full.
// Reset: clears the window, the queue and the output register, and loads
//   pattern_len = 1, all other registers 0.
// A stalled rsp holds its beat; req keeps being taken until the queue fills.
`default_nettype none

module stream_find_replace #(
   parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF,
   parameter int MAX_REPLACE = sfr_pkg::MAX_REPLACE_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   sfr_req_if.sink                          req,
   sfr_rsp_if.source                        rsp,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [sfr_pkg::ADDR_W-1:0]  csr_paddr,
   input  wire logic [sfr_pkg::DATA_W-1:0]  csr_pwdata,
   output logic      [sfr_pkg::DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   `include "assert_macros.svh"

   sfr_pkg::cfg_type       cfg_ff, cfg_in;
   sfr_pkg::reg_index_type wr_index;
   logic                   wr_en;
   logic                   cfg_clear;

   sfr_pkg::cmd_type q_wdata;
   sfr_pkg::cmd_type q_head;
   logic             q_push;
   logic             q_pop;
   logic             q_full;
   logic             q_empty;

   assign csr_pready = 1'b1;
   assign wr_index   = sfr_pkg::reg_index_type'(csr_paddr[4:3]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_clear  = wr_en && (wr_index == sfr_pkg::REG_PATTERN_LEN);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            sfr_pkg::REG_PATTERN_LEN:   cfg_in.pattern_len   = csr_pwdata[3:0];
            sfr_pkg::REG_PATTERN_BYTES: cfg_in.pattern_bytes = csr_pwdata;
            sfr_pkg::REG_REPLACE_LEN:   cfg_in.replace_len   = csr_pwdata[3:0];
            sfr_pkg::REG_REPLACE_BYTES: cfg_in.replace_bytes = csr_pwdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (wr_index)
         sfr_pkg::REG_PATTERN_LEN:   csr_prdata = {60'd0, cfg_ff.pattern_len};
         sfr_pkg::REG_PATTERN_BYTES: csr_prdata = cfg_ff.pattern_bytes;
         sfr_pkg::REG_REPLACE_LEN:   csr_prdata = {60'd0, cfg_ff.replace_len};
         sfr_pkg::REG_REPLACE_BYTES: csr_prdata = cfg_ff.replace_bytes;
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_len   <= sfr_pkg::PATTERN_LEN_RESET;
         cfg_ff.pattern_bytes <= '0;
         cfg_ff.replace_len   <= '0;
         cfg_ff.replace_bytes <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sfr_front #(
      .MAX_PATTERN (MAX_PATTERN),
      .MAX_REPLACE (MAX_REPLACE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cfg       (cfg_ff),
      .cfg_clear (cfg_clear),
      .q_full    (q_full),
      .q_wdata   (q_wdata),
      .q_push    (q_push)
   );

   sfr_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .head  (q_head),
      .full  (q_full),
      .empty (q_empty)
   );

   sfr_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (q_head),
      .empty (q_empty),
      .pop   (q_pop),
      .rsp   (rsp)
   );

   `SFR_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp.valid, "rsp valid after reset")
   `SFR_ASSERT(a_empty_beat_is_end, (rsp.valid && !rsp.has_char) |-> (rsp.out_last && rsp.out_char == 8'd0), "empty beat not a clean end beat")
   `SFR_ASSERT(a_pop_needs_entry, q_pop |-> !q_empty, "pop from empty command queue")

endmodule

`default_nettype wire

@@ tb/stream_find_replace_tb.sv @@
`timescale 1ns / 100ps

module stream_find_replace_tb;

   localparam int ITEM_GOAL      = 460;
   localparam int DRAIN_PAD      = 10;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD      = 120;

   typedef struct packed {
      logic [7:0] out_char;
      logic       has_char;
      logic       out_last;
   } out_beat_type;

   typedef struct packed {
      logic [7:0] in_char;
      logic       in_last;
   } text_byte_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [sfr_pkg::ADDR_W-1:0] csr_paddr;
   logic [sfr_pkg::DATA_W-1:0] csr_pwdata;
   logic [sfr_pkg::DATA_W-1:0] csr_prdata;
   logic                       csr_pready;

   sfr_req_if req_bus ();
   sfr_rsp_if rsp_bus ();

   stream_find_replace uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   text_byte_type pending_bytes[$];
   out_beat_type  expected_beats[$];
   int            in_flight;
   int            items_total;
   int            fail_count;
   int            idle_run;
   int            send_idle_pct;
   int            recv_idle_pct;
   logic          hold_req;
   logic          hold_done;
   int            hold_left;
   text_byte_type next_byte;
   out_beat_type  rsp_want;
   out_beat_type  rsp_got;

   // shadow of the block's registers and match window
   sfr_pkg::cfg_type model_cfg;
   logic [7:0]       window [sfr_pkg::MAX_PATTERN_DEF];
   int               window_fill;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int clip_pattern_len(logic [3:0] raw);
      if (raw == 4'd0) return 1;
      if (raw > sfr_pkg::MAX_PATTERN_DEF) return sfr_pkg::MAX_PATTERN_DEF;
      return int'(raw);
   endfunction

   function automatic void predict_rewrite(text_byte_type beat);
      int   plen;
      int   rlen;
      int   n;
      logic hit;
      plen = clip_pattern_len(model_cfg.pattern_len);
      rlen = (model_cfg.replace_len > sfr_pkg::MAX_REPLACE_DEF) ? sfr_pkg::MAX_REPLACE_DEF
                                                                : model_cfg.replace_len;
      n = 0;
      if (window_fill >= plen) window_fill = 0;
      window[window_fill] = beat.in_char;
      window_fill++;
      if (window_fill == plen) begin
         hit = 1'b1;
         for (int k = 0; k < plen; k++)
            if (window[k] != model_cfg.pattern_bytes[8*k +: 8]) hit = 1'b0;
         if (hit) begin
            for (int k = 0; k < rlen; k++) begin
               expected_beats.push_back(
                  out_beat_type'{model_cfg.replace_bytes[8*k +: 8], 1'b1, 1'b0});
               n++;
            end
            window_fill = 0;
         end else begin
            expected_beats.push_back(out_beat_type'{window[0], 1'b1, 1'b0});
            n++;
            for (int k = 1; k < plen; k++) window[k-1] = window[k];
            window_fill--;
         end
      end
      if (beat.in_last) begin
         for (int k = 0; k < window_fill; k++) begin
            expected_beats.push_back(out_beat_type'{window[k], 1'b1, 1'b0});
            n++;
         end
         window_fill = 0;
         if (n == 0) expected_beats.push_back(out_beat_type'{8'h00, 1'b0, 1'b1});
         else expected_beats[expected_beats.size()-1].out_last = 1'b1;
      end
   endfunction

   task automatic write_reg(sfr_pkg::reg_index_type idx, logic [63:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         sfr_pkg::REG_PATTERN_LEN: begin
            model_cfg.pattern_len = value[3:0];
            window_fill = 0;
         end
         sfr_pkg::REG_PATTERN_BYTES: model_cfg.pattern_bytes = value;
         sfr_pkg::REG_REPLACE_LEN:   model_cfg.replace_len = value[3:0];
         sfr_pkg::REG_REPLACE_BYTES: model_cfg.replace_bytes = value;
         default: ;
      endcase
   endtask

   task automatic configure(logic [3:0] plen, logic [63:0] pbytes,
                            logic [3:0] rlen, logic [63:0] rbytes);
      write_reg(sfr_pkg::REG_PATTERN_LEN, {60'd0, plen});
      write_reg(sfr_pkg::REG_PATTERN_BYTES, pbytes);
      write_reg(sfr_pkg::REG_REPLACE_LEN, {60'd0, rlen});
      write_reg(sfr_pkg::REG_REPLACE_BYTES, rbytes);
   endtask

   function automatic void queue_byte(logic [7:0] ch, logic last);
      pending_bytes.push_back(text_byte_type'{ch, last});
      in_flight++;
      items_total++;
   endfunction

   // drained once every queued byte is taken and every expected beat seen
   task automatic wait_drained();
      do @(posedge clock); while (in_flight != 0 || expected_beats.size() != 0);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic run_random_phase();
      logic [7:0]    alpha [4];
      logic [3:0]    plen_raw;
      logic [3:0]    rlen_raw;
      logic [63:0]   pbytes;
      int            plen;
      int            target;
      int            cnt;
      int            len;
      int            r;
      int            cut;
      text_byte_type text[$];

      for (int i = 0; i < 4; i++) alpha[i] = 8'($urandom_range(0, 255));
      r = $urandom_range(0, 19);
      if (r == 0) plen_raw = 4'd0;
      else if (r < 3) plen_raw = 4'($urandom_range(9, 15));
      else plen_raw = 4'($urandom_range(1, 8));
      plen = clip_pattern_len(plen_raw);
      pbytes = {$urandom, $urandom};
      for (int k = 0; k < plen; k++) pbytes[8*k +: 8] = alpha[$urandom_range(0, 3)];
      r = $urandom_range(0, 19);
      rlen_raw = (r < 2) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      configure(plen_raw, pbytes, rlen_raw, {$urandom, $urandom});

      if (items_total < 150) begin
         send_idle_pct <= 37;
         recv_idle_pct <= 66;
      end else if (items_total < 300) begin
         send_idle_pct <= 66;
         recv_idle_pct <= 37;
      end else begin
         send_idle_pct <= 0;
         recv_idle_pct <= 0;
         hold_req      <= 1'b1;
      end

      target = $urandom_range(30, 50);
      cnt = 0;
      while (cnt < target) begin
         len = $urandom_range(1, 16);
         text.delete();
         while (text.size() < len) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
               for (int k = 0; k < plen; k++)
                  text.push_back(text_byte_type'{pbytes[8*k +: 8], 1'b0});
            end else if (r < 38) begin
               cut = $urandom_range(1, plen);
               for (int k = 0; k < cut; k++)
                  text.push_back(text_byte_type'{pbytes[8*k +: 8], 1'b0});
            end else if (r < 55) begin
               text.push_back(text_byte_type'{8'($urandom_range(0, 255)), 1'b0});
            end else begin
               text.push_back(text_byte_type'{alpha[$urandom_range(0, 3)], 1'b0});
            end
         end
         cnt += text.size();
         // sometimes leave the last text open so the next pattern_len write lands mid-text
         if (cnt < target || $urandom_range(0, 3) != 0)
            text[text.size()-1].in_last = 1'b1;
         foreach (text[i]) queue_byte(text[i].in_char, text[i].in_last);
      end
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_rewrite(text_byte_type'{req_bus.in_char, req_bus.in_last});
            in_flight--;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_byte = pending_bytes.pop_front();
               req_bus.valid   <= 1'b1;
               req_bus.in_char <= next_byte.in_char;
               req_bus.in_last <= next_byte.in_last;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= 0;
         hold_done     <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_got = out_beat_type'{rsp_bus.out_char, rsp_bus.has_char, rsp_bus.out_last};
            if (expected_beats.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected rsp beat: char=%h has=%b last=%b",
                           rsp_got.out_char, rsp_got.has_char, rsp_got.out_last);
            end else begin
               rsp_want = expected_beats.pop_front();
               if (rsp_got.out_char !== rsp_want.out_char ||
                   rsp_got.has_char !== rsp_want.has_char ||
                   rsp_got.out_last !== rsp_want.out_last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"rsp mismatch: exp char=%h has=%b last=%b,",
                               " got char=%h has=%b last=%b"},
                              rsp_want.out_char, rsp_want.has_char, rsp_want.out_last,
                              rsp_got.out_char, rsp_got.has_char, rsp_got.out_last);
               end
            end
         end
         // one long hold-off so the command queue fills and req backs up
         if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else if (hold_req && !hold_done) begin
            hold_left     <= LONG_HOLD;
            hold_done     <= 1'b1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          csr_psel) begin
         idle_run <= 0;
      end else if (idle_run >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_run <= idle_run + 1;
      end
   end

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.in_char = 8'h00;
      req_bus.in_last = 1'b0;
      rsp_bus.ready   = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      hold_req        = 1'b0;
      in_flight       = 0;
      items_total     = 0;
      fail_count      = 0;
      idle_run        = 0;
      send_idle_pct   = 37;
      recv_idle_pct   = 66;
      model_cfg       = sfr_pkg::cfg_type'{sfr_pkg::PATTERN_LEN_RESET, 64'd0, 4'd0, 64'd0};
      window_fill     = 0;
      foreach (window[i]) window[i] = 8'h00;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // length 0 acts as 1; zero-length replacement deletes, a deleted last byte
      // leaves only the empty end beat
      configure(4'd0, {32'($urandom), 24'($urandom), 8'h41}, 4'd0, 64'd0);
      queue_byte(8'h41, 1'b1);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h41, 1'b0);
      queue_byte(8'h42, 1'b1);
      queue_byte(8'h41, 1'b0);
      queue_byte(8'h41, 1'b1);
      wait_drained();

      // full-width pattern, replace length saturates, text left open
      configure(4'd8, 64'h807F_01FE_00FF_55AA, 4'd15, 64'hC33C_00FF_A55A_0180);
      for (int k = 0; k < 8; k++) queue_byte(model_cfg.pattern_bytes[8*k +: 8], k == 7);
      queue_byte(8'h12, 1'b0);
      queue_byte(8'h34, 1'b0);
      queue_byte(8'h56, 1'b0);
      wait_drained();

      // pattern_len write mid-text drops the held bytes; 12 saturates to 8
      write_reg(sfr_pkg::REG_PATTERN_LEN, 64'd12);
      write_reg(sfr_pkg::REG_REPLACE_LEN, 64'd9);
      queue_byte(8'h33, 1'b1);
      wait_drained();

      configure(4'd3, {40'($urandom), 24'h80FF00}, 4'd1, {$urandom, $urandom});
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'hFF, 1'b1);
      wait_drained();

      while (items_total < ITEM_GOAL) run_random_phase();

      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/sfr_pkg.sv
rtl/core/sfr_req_if.sv
rtl/core/sfr_rsp_if.sv
rtl/core/sfr_front.sv
rtl/core/sfr_queue.sv
rtl/core/sfr_back.sv
rtl/core/stream_find_replace.sv
tb/stream_find_replace_tb.sv
